// ===== sv/stack_with_keyed_removal_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Stack with keyed removal - assertion macros
// Shared concurrent assertion forms for the stack unit.
// ---------------------------------------------------------------------------
`ifndef STACK_WITH_KEYED_REMOVAL_UNIT_ASSERT_SVH
`define STACK_WITH_KEYED_REMOVAL_UNIT_ASSERT_SVH

// same-cycle implication
`define SWKR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SWKR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/swkr_pkg.sv =====
// ---------------------------------------------------------------------------
// Stack with keyed removal - package
// Depth, widths, operation and status codes, controller states.
// ---------------------------------------------------------------------------
package swkr_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int REC_W  = 64;

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_POP_WAIT,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

endpackage

// ===== sv/stack_with_keyed_removal_unit.sv =====
// ---------------------------------------------------------------------------
// Stack with keyed removal unit
// Bounded LIFO of order records (id, distance, price) with push, pop and
// remove-by-id, backed by one synchronous single-read/single-write RAM.
// ---------------------------------------------------------------------------
// Each transaction gives exactly one result. The search reads one record per
// cycle up to a hit at index k, and the compaction then copies the N - 1 - k
// records above it at one per cycle, for N held records; the one RAM read port
// sets this. One transaction is in work at a time; a new one is accepted while
// a finished result still waits on the output register.
// ---------------------------------------------------------------------------
`include "stack_with_keyed_removal_unit_assert.svh"

module stack_with_keyed_removal_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // operation
    input  logic [63:0] s_tdata,   // key_id[15:0], in_distance[31:16], in_price[63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,   // status
    output logic [71:0] m_tdata    // out_id[15:0], out_distance[31:16], out_price[63:32],
                                   // entry_count[68:64], zero[71:69]
);

    localparam int AW = swkr_pkg::ADDR_W;
    localparam int CW = swkr_pkg::CNT_W;
    localparam int EW = (CW > 5) ? CW : 5;

    swkr_pkg::state_t state_reg, state_next;

    logic [1:0]                 op_reg;
    logic [15:0]                key_reg;
    logic [15:0]                dist_reg;
    logic [31:0]                price_reg;
    logic [CW-1:0]              count_reg, count_next;
    logic [AW-1:0]              idx_reg, idx_next;
    logic [1:0]                 res_status_reg, res_status_next;
    logic [swkr_pkg::REC_W-1:0] res_rec_reg, res_rec_next;

    logic                       m_tvalid_reg;
    logic [1:0]                 m_tuser_reg;
    logic [71:0]                m_tdata_reg;

    logic [swkr_pkg::REC_W-1:0] record_mem [swkr_pkg::DEPTH];
    logic [swkr_pkg::REC_W-1:0] rd_data_reg;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [swkr_pkg::REC_W-1:0] wr_data;

    logic [CW:0]                idx_p1;
    logic [CW:0]                idx_p2;
    logic [CW:0]                cnt_ext;
    logic                       hit;
    logic                       out_free;
    logic                       out_load;
    logic [EW-1:0]              count_wide;

    assign idx_p1     = (CW + 1)'(idx_reg) + 1'b1;
    assign idx_p2     = (CW + 1)'(idx_reg) + 2'd2;
    assign cnt_ext    = (CW + 1)'(count_reg);
    assign hit        = (rd_data_reg[63:48] == key_reg);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign out_load   = (state_reg == swkr_pkg::S_DONE) && out_free;
    assign count_wide = EW'(count_reg);

    assign s_tready = (state_reg == swkr_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    // record RAM
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            record_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= record_mem[rd_addr];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            swkr_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    state_next = swkr_pkg::S_DISPATCH;
                end
            end
            swkr_pkg::S_DISPATCH: begin
                case (op_reg)
                    swkr_pkg::OP_POP: begin
                        state_next = (count_reg == '0) ? swkr_pkg::S_DONE
                                                       : swkr_pkg::S_POP_WAIT;
                    end
                    swkr_pkg::OP_REMOVE: begin
                        state_next = (count_reg == '0) ? swkr_pkg::S_DONE
                                                       : swkr_pkg::S_SCAN;
                    end
                    default: state_next = swkr_pkg::S_DONE;
                endcase
            end
            swkr_pkg::S_POP_WAIT: state_next = swkr_pkg::S_DONE;
            swkr_pkg::S_SCAN: begin
                if (idx_p1 >= cnt_ext) begin
                    state_next = swkr_pkg::S_DONE;
                end else if (hit) begin
                    state_next = swkr_pkg::S_SHIFT;
                end
            end
            swkr_pkg::S_SHIFT: begin
                if (idx_p2 >= cnt_ext) begin
                    state_next = swkr_pkg::S_DONE;
                end
            end
            swkr_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = swkr_pkg::S_IDLE;
                end
            end
            default: state_next = swkr_pkg::S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        count_next      = count_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_rec_next    = res_rec_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = rd_data_reg;
        unique case (state_reg)
            swkr_pkg::S_DISPATCH: begin
                res_status_next = swkr_pkg::ST_OK;
                res_rec_next    = '0;
                case (op_reg)
                    swkr_pkg::OP_PUSH: begin
                        if (count_reg >= CW'(swkr_pkg::DEPTH)) begin
                            res_status_next = swkr_pkg::ST_FULL;
                        end else begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[AW-1:0];
                            wr_data    = {key_reg, dist_reg, price_reg};
                            count_next = count_reg + 1'b1;
                        end
                    end
                    swkr_pkg::OP_POP: begin
                        if (count_reg == '0) begin
                            res_status_next = swkr_pkg::ST_EMPTY;
                        end else begin
                            rd_en      = 1'b1;
                            rd_addr    = AW'(count_reg - 1'b1);
                            count_next = count_reg - 1'b1;
                        end
                    end
                    swkr_pkg::OP_REMOVE: begin
                        if (count_reg == '0) begin
                            res_status_next = swkr_pkg::ST_NOT_FOUND;
                        end else begin
                            rd_en    = 1'b1;
                            rd_addr  = '0;
                            idx_next = '0;
                        end
                    end
                    default: ;
                endcase
            end
            swkr_pkg::S_POP_WAIT: begin
                res_rec_next = rd_data_reg;
            end
            swkr_pkg::S_SCAN: begin
                if (hit) begin
                    res_rec_next = rd_data_reg;
                    if (idx_p1 < cnt_ext) begin
                        rd_en   = 1'b1;
                        rd_addr = idx_p1[AW-1:0];
                    end else begin
                        count_next = count_reg - 1'b1;
                    end
                end else if (idx_p1 < cnt_ext) begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_p1[AW-1:0];
                    idx_next = idx_p1[AW-1:0];
                end else begin
                    res_status_next = swkr_pkg::ST_NOT_FOUND;
                end
            end
            swkr_pkg::S_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = rd_data_reg;
                if (idx_p2 < cnt_ext) begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_p2[AW-1:0];
                    idx_next = idx_p1[AW-1:0];
                end else begin
                    count_next = count_reg - 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= swkr_pkg::S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_rec_reg    <= res_rec_next;
        if (s_tvalid && s_tready) begin
            op_reg    <= s_tuser;
            key_reg   <= s_tdata[15:0];
            dist_reg  <= s_tdata[31:16];
            price_reg <= s_tdata[63:32];
        end
        if (out_load) begin
            m_tuser_reg <= res_status_reg;
            m_tdata_reg <= {3'b000, count_wide[4:0], res_rec_reg[31:0],
                            res_rec_reg[47:32], res_rec_reg[63:48]};
        end
    end

    `SWKR_ASSERT_IMPLY(a_count_bound, aclk, aresetn, 1'b1,
        count_reg <= CW'(swkr_pkg::DEPTH), "entry count above depth")
    `SWKR_ASSERT_IMPLY(a_shift_range, aclk, aresetn, state_reg == swkr_pkg::S_SHIFT,
        idx_p1 < cnt_ext, "compaction source beyond top")
    `SWKR_ASSERT_IMPLY(a_write_source, aclk, aresetn, wr_en,
        state_reg == swkr_pkg::S_SHIFT || state_reg == swkr_pkg::S_DISPATCH,
        "RAM write outside push or compaction")
    `SWKR_ASSERT_NEXT(a_push_count, aclk, aresetn,
        state_reg == swkr_pkg::S_DISPATCH && op_reg == swkr_pkg::OP_PUSH &&
        count_reg < CW'(swkr_pkg::DEPTH),
        count_reg == $past(count_reg) + 1'b1, "push did not advance count")

endmodule

// ===== bench/stack_with_keyed_removal_unit_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stack with keyed removal unit - testbench
// Drives push, pop, keyed removal and the unused operation code into the
// stack. A shadow stack of order records predicts every response, and each
// response is checked field by field against the oldest prediction. Directed
// cases cover the empty and full stack, duplicate ids and misses. Random
// phases follow, with and without gaps on the input side and stalls on the output side.
// ---------------------------------------------------------------------------
module stack_with_keyed_removal_unit_test;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 2 * swkr_pkg::DEPTH + 8;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] key;
        logic [15:0] distance;
        logic [31:0] price;
    } order_req_t;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] distance;
        logic [31:0] price;
    } order_rec_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] id;
        logic [15:0] distance;
        logic [31:0] price;
        logic [4:0]  count;
    } order_resp_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser = '0;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [1:0]  m_tuser;
    logic [71:0] m_tdata;

    order_rec_t  held_records [swkr_pkg::DEPTH];
    int          held_count = 0;
    order_resp_t pending_resp_q [$];

    bit gaps_on = 1'b0;
    bit stalls_on = 1'b0;
    int ready_hold = 0;

    int n_push = 0, n_full = 0, n_pop = 0, n_empty = 0;
    int n_remove = 0, n_miss = 0, n_unused = 0;
    int n_checked = 0, n_errors = 0;

    stack_with_keyed_removal_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),   // operation
        .s_tdata  (s_tdata),   // key_id, in_distance, in_price
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),   // status
        .m_tdata  (m_tdata)    // out_id, out_distance, out_price, entry_count, zero
    );

    always #2 aclk = ~aclk;

    // mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic order_resp_t predict_order(input order_req_t req);
        order_resp_t resp;
        int hit;
        resp = '0;
        hit = -1;
        case (req.op)
            swkr_pkg::OP_PUSH: begin
                n_push++;
                if (held_count >= swkr_pkg::DEPTH) begin
                    resp.status = swkr_pkg::ST_FULL;
                    n_full++;
                end else begin
                    held_records[held_count] = '{id: req.key, distance: req.distance,
                                                 price: req.price};
                    held_count++;
                    resp.status = swkr_pkg::ST_OK;
                end
            end
            swkr_pkg::OP_POP: begin
                n_pop++;
                if (held_count == 0) begin
                    resp.status = swkr_pkg::ST_EMPTY;
                    n_empty++;
                end else begin
                    held_count--;
                    resp.status   = swkr_pkg::ST_OK;
                    resp.id       = held_records[held_count].id;
                    resp.distance = held_records[held_count].distance;
                    resp.price    = held_records[held_count].price;
                end
            end
            swkr_pkg::OP_REMOVE: begin
                n_remove++;
                for (int i = 0; i < held_count && hit < 0; i++) begin
                    if (held_records[i].id == req.key) hit = i;
                end
                if (hit < 0) begin
                    resp.status = swkr_pkg::ST_NOT_FOUND;
                    n_miss++;
                end else begin
                    resp.status   = swkr_pkg::ST_OK;
                    resp.id       = held_records[hit].id;
                    resp.distance = held_records[hit].distance;
                    resp.price    = held_records[hit].price;
                    for (int j = hit; j < held_count - 1; j++) begin
                        held_records[j] = held_records[j + 1];
                    end
                    held_count--;
                end
            end
            default: begin
                n_unused++;
                resp.status = swkr_pkg::ST_OK;
            end
        endcase
        resp.count = held_count[4:0];
        return resp;
    endfunction

    // called at a rising edge; leaves tvalid high after the handshake
    task automatic send_order(input logic [1:0] op, input logic [15:0] key,
                              input logic [15:0] distance, input logic [31:0] price);
        int gap;
        order_req_t req;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {price, distance, key};
        do @(posedge aclk); while (!s_tready);
        req = '{op: op, key: key, distance: distance, price: price};
        pending_resp_q.push_back(predict_order(req));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_resp_q.size() != 0);
    endtask

    // response check and output-side stalls
    always @(posedge aclk) begin
        order_resp_t exp_resp;
        if (aresetn && m_tvalid && m_tready) begin
            n_checked++;
            if (pending_resp_q.size() == 0) begin
                $error("unexpected transaction: status %0d data %h", m_tuser, m_tdata);
                n_errors++;
            end else begin
                exp_resp = pending_resp_q.pop_front();
                if (m_tuser !== exp_resp.status) begin
                    $error("status expected %0d actual %0d", exp_resp.status, m_tuser);
                    n_errors++;
                end
                if (m_tdata[15:0] !== exp_resp.id) begin
                    $error("out_id expected %h actual %h", exp_resp.id, m_tdata[15:0]);
                    n_errors++;
                end
                if (m_tdata[31:16] !== exp_resp.distance) begin
                    $error("out_distance expected %h actual %h", exp_resp.distance,
                           m_tdata[31:16]);
                    n_errors++;
                end
                if (m_tdata[63:32] !== exp_resp.price) begin
                    $error("out_price expected %h actual %h", exp_resp.price,
                           m_tdata[63:32]);
                    n_errors++;
                end
                if (m_tdata[68:64] !== exp_resp.count) begin
                    $error("entry_count expected %0d actual %0d", exp_resp.count,
                           m_tdata[68:64]);
                    n_errors++;
                end
                if (m_tdata[71:69] !== 3'b000) begin
                    $error("pad bits expected 0 actual %b", m_tdata[71:69]);
                    n_errors++;
                end
            end
        end
        if (ready_hold > 0) begin
            ready_hold--;
        end else if (stalls_on && $urandom_range(0, 2) == 0) begin
            m_tready   <= 1'b0;
            ready_hold  = pick_gap();
        end else begin
            m_tready   <= 1'b1;
            ready_hold  = $urandom_range(0, 6);
        end
    end

    task automatic test_empty_stack();
        send_order(swkr_pkg::OP_POP, 16'h0000, 16'h0000, 32'h0);
        send_order(swkr_pkg::OP_REMOVE, 16'h0000, 16'h0000, 32'h0);
        send_order(OP_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    endtask

    // ids 0x1234 twice for the duplicate case, others unique
    task automatic test_fill_and_full();
        for (int i = 0; i < swkr_pkg::DEPTH; i++) begin
            if (i == 0)
                send_order(swkr_pkg::OP_PUSH, 16'hFFFF, 16'h0000, 32'h0);
            else if (i == 1)
                send_order(swkr_pkg::OP_PUSH, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
            else if (i == 2 || i == 5)
                send_order(swkr_pkg::OP_PUSH, 16'h1234, 16'($urandom), $urandom);
            else
                send_order(swkr_pkg::OP_PUSH, 16'h0100 + 16'(i), 16'($urandom),
                           $urandom);
        end
        send_order(swkr_pkg::OP_PUSH, 16'hAAAA, 16'h5555, 32'hA5A5_5A5A);
        send_order(OP_UNUSED, 16'h0000, 16'h0000, 32'h0);
    endtask

    task automatic test_removal_by_key();
        send_order(swkr_pkg::OP_REMOVE, 16'h1234, 16'h0, 32'h0);
        send_order(swkr_pkg::OP_REMOVE, 16'hFFFF, 16'h0, 32'h0);
        send_order(swkr_pkg::OP_REMOVE, 16'hBEEF, 16'h0, 32'h0);
        send_order(swkr_pkg::OP_REMOVE, 16'h0100 + 16'(swkr_pkg::DEPTH - 1), 16'h0,
                   32'h0);
        send_order(swkr_pkg::OP_POP, 16'h0, 16'h0, 32'h0);
        wait_drained();
    endtask

    // modes: 0 filling, 1 emptying, 2 balanced
    task automatic test_random_mix(input int n_items, input bit with_gaps,
                                   input bit with_stalls);
        int mode, mode_left, r, push_pct;
        logic [1:0]  op;
        logic [15:0] key;
        gaps_on   = with_gaps;
        stalls_on = with_stalls;
        mode      = 2;
        mode_left = 0;
        for (int n = 0; n < n_items; n++) begin
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            push_pct = (mode == 0) ? 75 : (mode == 1) ? 20 : 45;
            r = $urandom_range(0, 99);
            if (r < 3)
                op = OP_UNUSED;
            else if (r < 3 + push_pct)
                op = swkr_pkg::OP_PUSH;
            else if ($urandom_range(0, 1) == 0)
                op = swkr_pkg::OP_POP;
            else
                op = swkr_pkg::OP_REMOVE;
            if (op == swkr_pkg::OP_REMOVE && held_count > 0 && $urandom_range(0, 3) != 0)
                key = held_records[$urandom_range(0, held_count - 1)].id;
            else if ($urandom_range(0, 1) == 0)
                key = 16'($urandom_range(0, 15));
            else
                key = 16'($urandom);
            send_order(op, key, 16'($urandom), $urandom);
        end
        wait_drained();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_stack();
        test_fill_and_full();
        test_removal_by_key();
        test_random_mix(215, 1'b0, 1'b0);
        test_random_mix(215, 1'b1, 1'b1);
        test_random_mix(215, 1'b1, 1'b0);
        test_random_mix(215, 1'b0, 1'b1);

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_resp_q.size() != 0) begin
            $error("%0d responses never arrived", pending_resp_q.size());
            n_errors++;
        end
        $display("pushes %0d (%0d refused full), pops %0d (%0d on empty),",
                 n_push, n_full, n_pop, n_empty);
        $display("removals %0d (%0d missed), unused codes %0d; %0d responses checked",
                 n_remove, n_miss, n_unused, n_checked);
        if (n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout: %0d responses outstanding", pending_resp_q.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
